>>> rtl/core/tsr_pkg.sv
// Shared types, widths and codes for the triangle span rasterizer.
package tsr_pkg;

  localparam int COORD_BITS = 12;
  localparam int COLOR_W    = 16;
  localparam int ACC_W      = 2 * COORD_BITS + 2;
  localparam int CNT_W      = $clog2(COORD_BITS);
  localparam int S_DATA_W   = ((6 * COORD_BITS + COLOR_W + 7) / 8) * 8;
  localparam int M_DATA_W   = ((3 * COORD_BITS + COLOR_W + 7) / 8) * 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] ucoord_t;
  typedef logic        [COLOR_W-1:0]    color_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

  // one edge evaluation: xa + (xb - xa) * k / h, sum truncated toward zero
  typedef struct packed {
    coord_t  xa;
    coord_t  xb;
    ucoord_t k;
    ucoord_t h;
  } edge_req_t;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN_A,
    ST_WAIT_A,
    ST_RUN_B,
    ST_WAIT_B,
    ST_EMIT
  } tsr_state_t;

  typedef enum logic [1:0] {
    IP_IDLE,
    IP_MUL,
    IP_DIV,
    IP_DONE
  } ip_state_t;

endpackage

>>> rtl/core/tsr_interp.sv
// Bit-serial edge interpolator: serial multiply-accumulate then restoring divide.
module tsr_interp (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  tsr_pkg::edge_req_t  req,
  output logic                done,
  output tsr_pkg::coord_t     result
);

  localparam int C = tsr_pkg::COORD_BITS;
  localparam int A = tsr_pkg::ACC_W;

  tsr_pkg::ip_state_t state, state_next;

  logic [tsr_pkg::CNT_W-1:0] cnt;
  logic                      cnt_last;
  tsr_pkg::coord_t           xa;
  logic signed [C:0]         dx;
  tsr_pkg::ucoord_t          h_sr;
  tsr_pkg::ucoord_t          k_sr;
  tsr_pkg::ucoord_t          h;
  logic signed [A-1:0]       acc;
  logic signed [A-1:0]       acc_next;
  logic [A-1:0]              acc_mag;
  logic [A-1:0]              rem;
  logic [A-1:0]              dvs;
  logic                      neg;
  tsr_pkg::ucoord_t          q;
  logic [C:0]                q_signed;

  assign cnt_last = (cnt == tsr_pkg::CNT_W'(C - 1));

  // MSB first: acc = 2*acc + h_bit*xa + k_bit*dx
  always_comb begin
    acc_next = (acc <<< 1)
             + (h_sr[C-1] ? {{(A-C){xa[C-1]}}, xa} : '0)
             + (k_sr[C-1] ? {{(A-C-1){dx[C]}}, dx} : '0);
    acc_mag  = acc_next[A-1] ? (~acc_next + 1'b1) : acc_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      tsr_pkg::IP_IDLE: if (start) state_next = tsr_pkg::IP_MUL;
      tsr_pkg::IP_MUL:  if (cnt_last) state_next = tsr_pkg::IP_DIV;
      tsr_pkg::IP_DIV:  if (cnt_last) state_next = tsr_pkg::IP_DONE;
      tsr_pkg::IP_DONE: state_next = tsr_pkg::IP_IDLE;
      default:          state_next = tsr_pkg::IP_IDLE;
    endcase
  end

  always_comb begin
    q_signed = neg ? (~{1'b0, q} + 1'b1) : {1'b0, q};
    done     = (state == tsr_pkg::IP_DONE);
    result   = q_signed[C-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsr_pkg::IP_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      tsr_pkg::IP_IDLE: begin
        if (start) begin
          xa   <= req.xa;
          dx   <= {req.xb[C-1], req.xb} - {req.xa[C-1], req.xa};
          h_sr <= req.h;
          k_sr <= req.k;
          h    <= req.h;
          acc  <= '0;
          cnt  <= '0;
        end
      end
      tsr_pkg::IP_MUL: begin
        acc  <= acc_next;
        h_sr <= h_sr << 1;
        k_sr <= k_sr << 1;
        cnt  <= cnt + 1'b1;
        if (cnt_last) begin
          rem <= acc_mag;
          neg <= acc_next[A-1];
          dvs <= {{(A-C){1'b0}}, h} << (C - 1);
          q   <= '0;
          cnt <= '0;
        end
      end
      tsr_pkg::IP_DIV: begin
        if (rem >= dvs) begin
          rem <= rem - dvs;
          q   <= {q[C-2:0], 1'b1};
        end else begin
          q   <= {q[C-2:0], 1'b0};
        end
        dvs <= dvs >> 1;
        cnt <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/core/triangle_span_rasterizer.sv
// Triangle span rasterizer: loads a triangle, then emits one span per step beat.
// Load beat: no result; input ready again the next cycle.
// Step beat on an edged triangle: edge evaluations A and B run in turn on the shared serial
//   unit, then EMIT; input is ready again once the span is in the output register.
// Step beat when idle or on a flat triangle: straight to EMIT, ready once loaded.
// Synchronous reset clears the control state: no triangle active, output empty.
module triangle_span_rasterizer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // ax, ay, bx, by, cx, cy, fill_color (lowest bit up)
  input  logic [tsr_pkg::S_DATA_W-1:0]  s_axis_tdata,
  // command
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // row, left_x, right_x, span_color, zero pad (lowest bit up)
  output logic [tsr_pkg::M_DATA_W-1:0]  m_axis_tdata,
  // span_valid
  output logic                          m_axis_tuser,
  // last_span
  output logic                          m_axis_tlast
);

  localparam int C  = tsr_pkg::COORD_BITS;
  localparam int CW = tsr_pkg::COLOR_W;

  tsr_pkg::tsr_state_t state, state_next;

  tsr_pkg::vertex_t   top_v, mid_v, bot_v;
  tsr_pkg::color_t    held_color;
  tsr_pkg::ucoord_t   row_index;
  logic               active;
  logic               flat_case;

  tsr_pkg::vertex_t   in_a, in_b, in_c;
  tsr_pkg::vertex_t   srt0, srt1, srt2, tmp;
  tsr_pkg::ucoord_t   upper, total, lower_h;
  logic               lower, step_last;
  tsr_pkg::coord_t    flat_min, flat_max;

  tsr_pkg::edge_req_t req_a, req_b, ip_req;
  logic               ip_start, ip_done;
  tsr_pkg::coord_t    ip_result;
  tsr_pkg::coord_t    ea;

  logic               valid_w, last_w;
  tsr_pkg::coord_t    row_w, lx_w, rx_w;
  tsr_pkg::color_t    color_w;

  logic               out_user, out_last;
  tsr_pkg::coord_t    out_row, out_lx, out_rx;
  tsr_pkg::color_t    out_color;

  logic               s_accept, out_free, out_load;

  assign s_accept = s_axis_tvalid && s_axis_tready;

  // input unpack and three-stage sort on y (swap only on strictly greater)
  always_comb begin
    in_a.x = s_axis_tdata[C-1:0];
    in_a.y = s_axis_tdata[2*C-1:C];
    in_b.x = s_axis_tdata[3*C-1:2*C];
    in_b.y = s_axis_tdata[4*C-1:3*C];
    in_c.x = s_axis_tdata[5*C-1:4*C];
    in_c.y = s_axis_tdata[6*C-1:5*C];
    tmp  = in_a;
    srt0 = in_a;
    srt1 = in_b;
    srt2 = in_c;
    if ($signed(srt0.y) > $signed(srt1.y)) begin
      tmp = srt0; srt0 = srt1; srt1 = tmp;
    end
    if ($signed(srt0.y) > $signed(srt2.y)) begin
      tmp = srt0; srt0 = srt2; srt2 = tmp;
    end
    if ($signed(srt1.y) > $signed(srt2.y)) begin
      tmp = srt1; srt1 = srt2; srt2 = tmp;
    end
  end

  // per-row setup; heights fit unsigned since vertices are sorted
  always_comb begin
    upper     = tsr_pkg::ucoord_t'(mid_v.y - top_v.y);
    total     = tsr_pkg::ucoord_t'(bot_v.y - top_v.y);
    lower_h   = tsr_pkg::ucoord_t'(bot_v.y - mid_v.y);
    lower     = (row_index > upper) || (upper == '0);
    step_last = ({1'b0, row_index} + {{C{1'b0}}, 1'b1}) >= {1'b0, total};

    flat_min = top_v.x;
    flat_max = top_v.x;
    if ($signed(mid_v.x) < $signed(flat_min)) flat_min = mid_v.x;
    if ($signed(bot_v.x) < $signed(flat_min)) flat_min = bot_v.x;
    if ($signed(mid_v.x) > $signed(flat_max)) flat_max = mid_v.x;
    if ($signed(bot_v.x) > $signed(flat_max)) flat_max = bot_v.x;
  end

  always_comb begin
    state_next = state;
    case (state)
      tsr_pkg::ST_IDLE: begin
        if (s_accept && s_axis_tuser == tsr_pkg::CMD_STEP) begin
          if (active && !flat_case) state_next = tsr_pkg::ST_RUN_A;
          else                      state_next = tsr_pkg::ST_EMIT;
        end
      end
      tsr_pkg::ST_RUN_A:  state_next = tsr_pkg::ST_WAIT_A;
      tsr_pkg::ST_WAIT_A: if (ip_done) state_next = tsr_pkg::ST_RUN_B;
      tsr_pkg::ST_RUN_B:  state_next = tsr_pkg::ST_WAIT_B;
      tsr_pkg::ST_WAIT_B: if (ip_done) state_next = tsr_pkg::ST_EMIT;
      tsr_pkg::ST_EMIT:   if (out_free) state_next = tsr_pkg::ST_IDLE;
      default:            state_next = tsr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == tsr_pkg::ST_IDLE);
    ip_start      = (state == tsr_pkg::ST_RUN_A) || (state == tsr_pkg::ST_RUN_B);
    ip_req        = (state == tsr_pkg::ST_RUN_B) ? req_b : req_a;
    out_free      = !m_axis_tvalid || m_axis_tready;
    out_load      = (state == tsr_pkg::ST_EMIT) && out_free;
  end

  tsr_interp u_interp (
    .clk    (clk),
    .rst    (rst),
    .start  (ip_start),
    .req    (ip_req),
    .done   (ip_done),
    .result (ip_result)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= tsr_pkg::ST_IDLE;
      active        <= 1'b0;
      flat_case     <= 1'b0;
      row_index     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load)           m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      if (s_accept) begin
        if (s_axis_tuser == tsr_pkg::CMD_LOAD) begin
          active    <= 1'b1;
          flat_case <= (srt0.y == srt2.y);
          row_index <= '0;
        end else if (active) begin
          if (flat_case || step_last) begin
            active    <= 1'b0;
            row_index <= '0;
          end else begin
            row_index <= row_index + 1'b1;
          end
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (s_accept) begin
      if (s_axis_tuser == tsr_pkg::CMD_LOAD) begin
        top_v      <= srt0;
        mid_v      <= srt1;
        bot_v      <= srt2;
        held_color <= s_axis_tdata[6*C+CW-1:6*C];
      end else if (!active) begin
        valid_w <= 1'b0;
        last_w  <= 1'b0;
        row_w   <= '0;
        lx_w    <= '0;
        rx_w    <= '0;
        color_w <= '0;
      end else if (flat_case) begin
        valid_w <= 1'b1;
        last_w  <= 1'b1;
        row_w   <= top_v.y;
        lx_w    <= flat_min;
        rx_w    <= flat_max;
        color_w <= held_color;
      end else begin
        valid_w  <= 1'b1;
        last_w   <= step_last;
        row_w    <= top_v.y + row_index;
        color_w  <= held_color;
        req_a.xa <= top_v.x;
        req_a.xb <= bot_v.x;
        req_a.k  <= row_index;
        req_a.h  <= total;
        if (lower) begin
          req_b.xa <= mid_v.x;
          req_b.xb <= bot_v.x;
          req_b.k  <= row_index - upper;
          req_b.h  <= lower_h;
        end else begin
          req_b.xa <= top_v.x;
          req_b.xb <= mid_v.x;
          req_b.k  <= row_index;
          req_b.h  <= upper;
        end
      end
    end

    if (state == tsr_pkg::ST_WAIT_A && ip_done) ea <= ip_result;
    if (state == tsr_pkg::ST_WAIT_B && ip_done) begin
      if ($signed(ea) > $signed(ip_result)) begin
        lx_w <= ip_result;
        rx_w <= ea;
      end else begin
        lx_w <= ea;
        rx_w <= ip_result;
      end
    end

    if (out_load) begin
      out_user  <= valid_w;
      out_last  <= last_w;
      out_row   <= row_w;
      out_lx    <= lx_w;
      out_rx    <= rx_w;
      out_color <= color_w;
    end
  end

  always_comb begin
    m_axis_tdata               = '0;
    m_axis_tdata[C-1:0]        = out_row;
    m_axis_tdata[2*C-1:C]      = out_lx;
    m_axis_tdata[3*C-1:2*C]    = out_rx;
    m_axis_tdata[3*C+CW-1:3*C] = out_color;
    m_axis_tuser               = out_user;
    m_axis_tlast               = out_last;
  end

endmodule

>>> rtl/core/tsr_checker.sv
// Port-level checks for the triangle span rasterizer, bound to the top level.
module tsr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [tsr_pkg::S_DATA_W-1:0]  s_axis_tdata,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tsr_pkg::M_DATA_W-1:0]  m_axis_tdata,
  input logic                          m_axis_tuser,
  input logic                          m_axis_tlast
);

  localparam int C = tsr_pkg::COORD_BITS;

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // no-triangle result is all zero
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0 && !m_axis_tlast)
    else $error("invalid span carries data");

  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("last marked on invalid span");

  a_span_order: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      $signed(m_axis_tdata[2*C-1:C]) <= $signed(m_axis_tdata[3*C-1:2*C]))
    else $error("span ends out of order");

endmodule

bind triangle_span_rasterizer tsr_checker u_tsr_checker (.*);
